// ===== hdl/imuwa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuwa_pkg
// Shared constants for the IMU window average and motion detect block.
// ----------------------------------------------------------------------------
package imuwa_pkg;

    // channel layout: three gyro axes, then three accel axes
    localparam int CHANNELS = 6;
    localparam int FIELD_W  = 16;

    // default build values
    localparam int IMUWA_WINDOW      = 100;
    localparam int IMUWA_SAMPLE_BITS = 16;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = CHANNELS * FIELD_W;
    localparam int OUT_TDATA_W = ((CHANNELS * FIELD_W + 2 + 7) / 8) * 8;

    // register file
    localparam int          PADDR_W         = 3;
    localparam int          REG_IDX_W       = 1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [15:0] THRESHOLD_RESET = 16'd1;

endpackage

// ===== hdl/imuwa_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuwa_store
// Single-port sample ring memory, registered read, read-before-write.
// ----------------------------------------------------------------------------
module imuwa_store
    import imuwa_pkg::*;
#(
    parameter int DEPTH = IMUWA_WINDOW * CHANNELS,
    parameter int WIDTH = IMUWA_SAMPLE_BITS
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // old contents come out while the new sample goes in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/imuwa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuwa_div
// Shared restoring divider: signed sum by unsigned fill count, one quotient
// bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module imuwa_div
    import imuwa_pkg::*;
#(
    parameter int SUM_W = IMUWA_SAMPLE_BITS + $clog2(IMUWA_WINDOW),
    parameter int DVS_W = $clog2(IMUWA_WINDOW + 1),
    parameter int Q_W   = IMUWA_SAMPLE_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    output logic                    done,
    output logic signed [Q_W-1:0]   quotient
);

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIX  = 3'b100
    } div_state_t;

    div_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [DVS_W-1:0]        rem_reg, rem_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic                    neg_reg, neg_next;
    logic signed [Q_W-1:0]   q_reg, q_next;
    logic [DVS_W:0]          trial;
    logic                    ge;
    logic [DVS_W:0]          diff;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[SUM_W-1];
                    quo_next   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
                    dvs_next   = divisor;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(SUM_W - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = D_FIX;
                end
            end
            D_FIX:
            begin
                q_next     = neg_reg ? -$signed(quo_reg[Q_W-1:0]) : $signed(quo_reg[Q_W-1:0]);
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    // a new division is only started while idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == D_IDLE))
        else $error("divider started while busy");

    // the result is flagged in the cycle after the sign fix
    a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_FIX) |=> done_reg)
        else $error("divider done missing after fix");

    // the divisor is never zero during a run
    a_dvs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_RUN) |-> (dvs_reg != '0))
        else $error("divide by zero");

endmodule

// ===== hdl/imu_window_average_motion_detect_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_window_average_motion_detect_core
// Sliding-window average of six IMU channels with a zero-motion flag.
// ----------------------------------------------------------------------------
// each item is written to the single-port sample memory and summed channel by
//   channel, then averaged by the shared one-bit-per-cycle divider that runs six
//   times per item; a new item is taken only once the last one's result has been
//   loaded into the output register, so input is held off while that is still full
// a finished result waits in the output register while the next item is taken
// reset: sums, fill count and ring slot cleared, threshold 1; the sample memory
//   is not cleared, entries are read only after they have been written
module imu_window_average_motion_detect_core
    import imuwa_pkg::*;
#(
    parameter int WINDOW      = IMUWA_WINDOW,
    parameter int SAMPLE_BITS = IMUWA_SAMPLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (16 bits each)
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // avg_gyro_x, avg_gyro_y, avg_gyro_z, avg_accel_x, avg_accel_y,
    // avg_accel_z (16 bits each), window_full, moving, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int SUM_W = SB + $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SLW   = $clog2(WINDOW);
    localparam int DEPTH = WINDOW * CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CHW   = $clog2(CHANNELS);
    localparam int DW    = (SB + 2 > 18) ? SB + 2 : 18;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_WR     = 7'b0000010,
        S_ACC    = 7'b0000100,
        S_DSTART = 7'b0001000,
        S_DWAIT  = 7'b0010000,
        S_CMP    = 7'b0100000,
        S_DONE   = 7'b1000000
    } seq_state_t;

    seq_state_t              state_reg, state_next;
    logic [CHW-1:0]          ch_reg, ch_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [SLW-1:0]          slot_reg, slot_next;
    logic [AW-1:0]           base_reg, base_next;
    logic                    full_old_reg, full_old_next;
    logic                    moving_reg, moving_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [15:0]             thr_reg;

    logic signed [SB-1:0]    sample_reg [CHANNELS];
    logic signed [SUM_W-1:0] sum_reg [CHANNELS];
    logic [15:0]             avg_work_reg [CHANNELS];
    logic [OUT_TDATA_W-1:0]  out_reg;

    logic                    cfg_wr;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    accept;
    logic                    out_load;
    logic                    st_en;
    logic [AW-1:0]           st_addr;
    logic signed [SB-1:0]    st_rdata;
    logic signed [SUM_W-1:0] sum_upd;
    logic                    div_start;
    logic                    div_done;
    logic signed [SB-1:0]    div_q;
    logic signed [DW-1:0]    dev;
    logic [DW-1:0]           dev_abs;
    logic                    over;
    logic signed [31:0]      avg_ext;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_THRESHOLD);

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = {16'd0, thr_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            thr_reg <= pwdata[15:0];
        end
    end

    // handshakes
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // ring memory access, one channel at a time
    assign st_en   = (state_reg == S_WR);
    assign st_addr = base_reg + AW'(ch_reg);

    imuwa_store #(
        .DEPTH (DEPTH),
        .WIDTH (SB)
    ) u_store (
        .clk   (clk),
        .en    (st_en),
        .we    (st_en),
        .addr  (st_addr),
        .wdata (sample_reg[ch_reg]),
        .rdata (st_rdata)
    );

    // running sum update: add newest, drop oldest once full
    always_comb
    begin
        sum_upd = sum_reg[ch_reg] + SUM_W'(sample_reg[ch_reg])
                - (full_old_reg ? SUM_W'(st_rdata) : SUM_W'(0));
    end

    // shared divider
    assign div_start = (state_reg == S_DSTART);

    imuwa_div #(
        .SUM_W (SUM_W),
        .DVS_W (CW),
        .Q_W   (SB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[ch_reg]),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // deviation of newest sample from its average
    always_comb
    begin
        dev     = DW'(sample_reg[ch_reg]) - DW'(div_q);
        dev_abs = dev[DW-1] ? DW'(-dev) : DW'(dev);
        over    = dev_abs > DW'(thr_reg);
        avg_ext = 32'(div_q);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        fill_next     = fill_reg;
        slot_next     = slot_reg;
        base_next     = base_reg;
        full_old_next = full_old_reg;
        moving_next   = moving_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    full_old_next = (fill_reg == CW'(WINDOW));
                    moving_next   = 1'b0;
                    ch_next       = '0;
                    state_next    = S_WR;
                end
            end
            S_WR:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (ch_reg == CHW'(CHANNELS - 1))
                begin
                    ch_next = '0;
                    if (!full_old_reg)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (slot_reg == SLW'(WINDOW - 1))
                    begin
                        slot_next = '0;
                        base_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                        base_next = base_reg + AW'(CHANNELS);
                    end
                    state_next = S_DSTART;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_WR;
                end
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (over && (fill_reg == CW'(WINDOW)))
                begin
                    moving_next = 1'b1;
                end
                if (ch_reg == CHW'(CHANNELS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_DSTART;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ch_reg       <= '0;
            fill_reg     <= '0;
            slot_reg     <= '0;
            base_reg     <= '0;
            full_old_reg <= 1'b0;
            moving_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            fill_reg     <= fill_next;
            slot_reg     <= slot_next;
            base_reg     <= base_next;
            full_old_reg <= full_old_next;
            moving_reg   <= moving_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // running sums, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (state_reg == S_ACC)
        begin
            sum_reg[ch_reg] <= sum_upd;
        end
    end

    // sample capture, averages and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sample_reg[c] <= $signed(SB'(32'(s_tdata[c*FIELD_W +: FIELD_W])));
            end
        end
        if (state_reg == S_CMP)
        begin
            avg_work_reg[ch_reg] <= avg_ext[15:0];
        end
        if (out_load)
        begin
            out_reg <= OUT_TDATA_W'({moving_reg, (fill_reg == CW'(WINDOW)),
                                     avg_work_reg[5], avg_work_reg[4], avg_work_reg[3],
                                     avg_work_reg[2], avg_work_reg[1], avg_work_reg[0]});
        end
    end

    // fill count never passes the window length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW))
        else $error("fill count beyond window");

    // an input transfer starts the update at the first channel
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_WR) && (ch_reg == '0))
        else $error("update did not start at channel zero");

    // a finished result is presented on the next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg)
        else $error("result not presented");

    // motion is only reported over a full window
    a_moving_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(out_reg[CHANNELS*FIELD_W + 1] && !out_reg[CHANNELS*FIELD_W]))
        else $error("motion flagged before window full");

endmodule
